// ===== sv/sml_lex_pkg.sv =====
// Shared types and constants for the slide markup block lexer.
package sml_lex_pkg;

  localparam int unsigned FIELD_W      = 24;
  localparam int unsigned POS_BITS_DEF = 24;
  localparam int unsigned PREFIX_W     = 3;
  localparam int unsigned IN_DEPTH     = 4;
  localparam int unsigned OUT_DEPTH    = 4;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_TICK  = 8'h60;

  localparam logic [PREFIX_W-1:0] SEP_DASHES  = 3'd3;
  localparam logic [PREFIX_W-1:0] HEAD_MAX    = 3'd6;
  localparam logic [PREFIX_W-1:0] FENCE_TICKS = 3'd3;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_END  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    KIND_SEP  = 3'd0,
    KIND_HEAD = 3'd1,
    KIND_CODE = 3'd2,
    KIND_PARA = 3'd3,
    KIND_END  = 3'd4
  } kind_e;

  typedef struct packed {
    logic       func;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [FIELD_W-1:0] text_start;
    logic [FIELD_W-1:0] text_length;
    logic [FIELD_W-1:0] widest_line;
    logic [FIELD_W-1:0] slides;
    logic               run_last;
  } out_item_t;

  typedef struct packed {
    logic is_nl;
    logic is_dash;
    logic is_hash;
    logic is_tick;
    logic is_space;
    logic is_tab;
  } char_class_t;

  typedef struct packed {
    logic        is_end;
    char_class_t cls;
  } lex_item_t;

endpackage

// ===== sv/slide_markup_block_lexer.sv =====
// Requests wait in the front queue until the lexer takes them, and results wait in the
// result queue. Throughput: one request per cycle unless a queue stalls; an end request
// yields up to two results, which leave at one per cycle while out_stall_i is low, through
// a four-entry result queue. The lexer waits while fewer than two result slots are free,
// and the four-entry front queue keeps taking requests meanwhile until it is full.
// Reset (rst_ni low, asynchronous): queues emptied, lexer between elements at zero, one slide.
module slide_markup_block_lexer
  import sml_lex_pkg::*;
#(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      head_valid;
  logic      head_pop;
  lex_item_t head_item;

  sml_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .head_pop_i   (head_pop)
  );

  sml_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .head_pop_o   (head_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

  // lexer only consumes a queued request
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> head_valid)
    else $error("lexer consumed from an empty front queue");

  // an accepted request is visible to the lexer on the next cycle
  a_accept_reaches_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> head_valid)
    else $error("accepted request missing from front queue");

  // an end request always produces a result
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_pop && head_item.is_end) |=> out_valid_o)
    else $error("end request produced no result");

endmodule

// ===== sv/sml_front.sv =====
// Front end: accepts requests, classifies the character and queues it for the lexer.
module sml_front
  import sml_lex_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      head_valid_o,
  output lex_item_t head_item_o,
  input  logic      head_pop_i
);

  localparam int unsigned PTR_W = $clog2(IN_DEPTH);
  localparam int unsigned CNT_W = $clog2(IN_DEPTH + 1);

  lex_item_t        queue_q [IN_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  lex_item_t        classified;

  assign in_stall_o   = (count_q == CNT_W'(IN_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = queue_q[rd_ptr_q];

  always_comb begin
    classified.is_end       = (in_item_i.func == FUNC_END);
    classified.cls.is_nl    = (in_item_i.text_byte == CHAR_NL);
    classified.cls.is_dash  = (in_item_i.text_byte == CHAR_DASH);
    classified.cls.is_hash  = (in_item_i.text_byte == CHAR_HASH);
    classified.cls.is_tick  = (in_item_i.text_byte == CHAR_TICK);
    classified.cls.is_space = (in_item_i.text_byte == CHAR_SPACE);
    classified.cls.is_tab   = (in_item_i.text_byte == CHAR_TAB);
  end

  always_comb begin
    wr_ptr_d = push ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = head_pop_i ? PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !head_pop_i) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (!push && head_pop_i) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= classified;
    end
  end

endmodule

// ===== sv/sml_back.sv =====
// Back end: block lexer state machine and result queue.
module sml_back
  import sml_lex_pkg::*;
#(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  lex_item_t head_item_i,
  output logic      head_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  typedef enum logic [3:0] {
    MODE_BETWEEN = 4'd0,
    MODE_SEP     = 4'd1,
    MODE_HHASH   = 4'd2,
    MODE_HBLANK  = 4'd3,
    MODE_HTEXT   = 4'd4,
    MODE_CTICK   = 4'd5,
    MODE_COPEN   = 4'd6,
    MODE_CLSTART = 4'd7,
    MODE_CLINE   = 4'd8,
    MODE_PLINE   = 4'd9,
    MODE_PLSTART = 4'd10
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [POS_BITS-1:0]  elem_start_q, elem_start_d;
  logic [POS_BITS-1:0]  line_start_q, line_start_d;
  logic [POS_BITS-1:0]  line_width_q, line_width_d;
  logic [POS_BITS-1:0]  widest_q, widest_d;
  logic [PREFIX_W-1:0]  prefix_q, prefix_d;
  logic [FIELD_W-1:0]   slide_q, slide_d;

  out_item_t            res_q [OUT_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     count_q, count_d;

  logic                 take;
  logic                 pop;
  logic                 r0_vld, r1_vld;
  out_item_t            r0, r1;
  logic [POS_BITS-1:0]  pos_inc, lw_inc, prefix_ext;
  logic [POS_BITS-1:0]  para_len, widest_line;
  char_class_t          cls;

  function automatic logic [FIELD_W-1:0] to_field(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, v};
    return ext[FIELD_W-1:0];
  endfunction

  function automatic out_item_t mk_rec(input kind_e k, input logic [POS_BITS-1:0] start,
                                       input logic [POS_BITS-1:0] len,
                                       input logic [POS_BITS-1:0] wide);
    out_item_t r;
    r.kind        = k;
    r.text_start  = to_field(start);
    r.text_length = to_field(len);
    r.widest_line = to_field(wide);
    r.slides      = '0;
    r.run_last    = 1'b1;
    return r;
  endfunction

  // Two free slots guarantee room for the worst case (element record plus end record).
  assign take       = head_valid_i && (count_q <= CNT_W'(OUT_DEPTH - 2));
  assign head_pop_o = take;
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = res_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  assign cls        = head_item_i.cls;
  assign pos_inc    = (pos_q == POS_MAX) ? pos_q : POS_BITS'(pos_q + 1'b1);
  assign lw_inc     = (line_width_q == POS_MAX) ? line_width_q
                                                : POS_BITS'(line_width_q + 1'b1);
  assign prefix_ext = POS_BITS'(prefix_q);
  assign para_len   = (pos_q > elem_start_q) ? POS_BITS'(pos_q - elem_start_q) : '0;
  assign widest_line = (line_width_q > widest_q) ? line_width_q : widest_q;

  always_comb begin
    mode_d       = mode_q;
    pos_d        = pos_q;
    elem_start_d = elem_start_q;
    line_start_d = line_start_q;
    line_width_d = line_width_q;
    widest_d     = widest_q;
    prefix_d     = prefix_q;
    slide_d      = slide_q;
    r0_vld       = 1'b0;
    r1_vld       = 1'b0;
    r0           = mk_rec(KIND_END, '0, '0, '0);
    r1           = mk_rec(KIND_END, '0, '0, '0);

    if (head_item_i.is_end) begin
      r0_vld = 1'b1;
      case (mode_q)
        MODE_SEP, MODE_HHASH, MODE_CTICK:
          r0 = mk_rec(KIND_PARA, elem_start_q, prefix_ext, prefix_ext);
        MODE_HBLANK:
          r0 = mk_rec(KIND_HEAD, pos_q, '0, '0);
        MODE_HTEXT:
          r0 = mk_rec(KIND_HEAD, elem_start_q, line_width_q, line_width_q);
        MODE_COPEN:
          r0 = mk_rec(KIND_CODE, pos_q, '0, '0);
        MODE_CLSTART, MODE_CLINE:
          r0 = mk_rec(KIND_CODE, elem_start_q, para_len, widest_line);
        MODE_PLINE, MODE_PLSTART:
          r0 = mk_rec(KIND_PARA, elem_start_q, para_len, widest_line);
        default:
          r0_vld = 1'b0;
      endcase
      r0.run_last = !r0_vld;
      r1          = mk_rec(KIND_END, '0, '0, '0);
      r1.slides   = slide_q;
      if (!r0_vld) begin
        r0     = r1;
        r0_vld = 1'b1;
      end else begin
        r1_vld = 1'b1;
      end
      // back to the reset state for the next text
      mode_d       = MODE_BETWEEN;
      pos_d        = '0;
      elem_start_d = '0;
      line_start_d = '0;
      line_width_d = '0;
      widest_d     = '0;
      prefix_d     = '0;
      slide_d      = FIELD_W'(1);
    end else begin
      pos_d = pos_inc;
      case (mode_q)
        MODE_SEP, MODE_HHASH, MODE_CTICK: begin
          if (mode_q == MODE_SEP && cls.is_dash && prefix_q < SEP_DASHES) begin
            prefix_d = PREFIX_W'(prefix_q + 1'b1);
          end else if (mode_q == MODE_SEP && prefix_q == SEP_DASHES && cls.is_nl) begin
            r0_vld = 1'b1;
            r0     = mk_rec(KIND_SEP, elem_start_q, '0, '0);
            if (slide_q != '1) slide_d = FIELD_W'(slide_q + 1'b1);
            mode_d = MODE_BETWEEN;
          end else if (mode_q == MODE_HHASH && cls.is_hash && prefix_q < HEAD_MAX) begin
            prefix_d = PREFIX_W'(prefix_q + 1'b1);
          end else if (mode_q == MODE_HHASH && cls.is_space) begin
            mode_d = MODE_HBLANK;
          end else if (mode_q == MODE_CTICK && cls.is_tick) begin
            prefix_d = PREFIX_W'(prefix_q + 1'b1);
            if (PREFIX_W'(prefix_q + 1'b1) >= FENCE_TICKS) mode_d = MODE_COPEN;
          end else begin
            // failed prefix: the bytes so far open a paragraph
            widest_d = '0;
            if (cls.is_nl) begin
              widest_d     = prefix_ext;
              line_width_d = '0;
              mode_d       = MODE_PLSTART;
            end else begin
              line_width_d = POS_BITS'(prefix_ext + 1'b1);
              mode_d       = MODE_PLINE;
            end
          end
        end
        MODE_HBLANK: begin
          if (cls.is_nl) begin
            r0_vld = 1'b1;
            r0     = mk_rec(KIND_HEAD, pos_q, '0, '0);
            mode_d = MODE_BETWEEN;
          end else if (!cls.is_space && !cls.is_tab) begin
            elem_start_d = pos_q;
            line_width_d = POS_BITS'(1);
            mode_d       = MODE_HTEXT;
          end
        end
        MODE_HTEXT: begin
          if (cls.is_nl) begin
            r0_vld = 1'b1;
            r0     = mk_rec(KIND_HEAD, elem_start_q, line_width_q, line_width_q);
            mode_d = MODE_BETWEEN;
          end else begin
            line_width_d = lw_inc;
          end
        end
        MODE_COPEN: begin
          if (cls.is_nl) begin
            elem_start_d = pos_inc;
            line_start_d = pos_inc;
            widest_d     = '0;
            line_width_d = '0;
            prefix_d     = '0;
            mode_d       = MODE_CLSTART;
          end
        end
        MODE_CLSTART, MODE_CLINE: begin
          if (mode_q == MODE_CLSTART && cls.is_tick && prefix_q < FENCE_TICKS) begin
            prefix_d     = PREFIX_W'(prefix_q + 1'b1);
            line_width_d = lw_inc;
          end else if (mode_q == MODE_CLSTART && cls.is_nl && prefix_q == FENCE_TICKS) begin
            r0_vld = 1'b1;
            r0     = mk_rec(KIND_CODE, elem_start_q,
                            (line_start_q > elem_start_q) ?
                              POS_BITS'(line_start_q - elem_start_q) : '0,
                            widest_q);
            mode_d = MODE_BETWEEN;
          end else if (cls.is_nl) begin
            widest_d     = widest_line;
            line_width_d = '0;
            line_start_d = pos_inc;
            prefix_d     = '0;
            mode_d       = MODE_CLSTART;
          end else begin
            line_width_d = lw_inc;
            mode_d       = MODE_CLINE;
          end
        end
        MODE_PLSTART: begin
          if (cls.is_nl) begin
            r0_vld = 1'b1;
            r0     = mk_rec(KIND_PARA, elem_start_q, para_len, widest_q);
            mode_d = MODE_BETWEEN;
          end else begin
            line_width_d = POS_BITS'(1);
            mode_d       = MODE_PLINE;
          end
        end
        MODE_PLINE: begin
          if (cls.is_nl) begin
            widest_d     = widest_line;
            line_width_d = '0;
            mode_d       = MODE_PLSTART;
          end else begin
            line_width_d = lw_inc;
          end
        end
        default: begin
          if (cls.is_nl) begin
            mode_d = MODE_BETWEEN;
          end else begin
            elem_start_d = pos_q;
            widest_d     = '0;
            prefix_d     = PREFIX_W'(1);
            if (cls.is_dash) begin
              mode_d = MODE_SEP;
            end else if (cls.is_hash) begin
              mode_d = MODE_HHASH;
            end else if (cls.is_tick) begin
              mode_d = MODE_CTICK;
            end else begin
              line_width_d = POS_BITS'(1);
              mode_d       = MODE_PLINE;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (take) begin
      count_d = CNT_W'(count_d + CNT_W'(r0_vld) + CNT_W'(r1_vld));
    end
    if (pop) begin
      count_d = CNT_W'(count_d - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_BETWEEN;
      pos_q        <= '0;
      elem_start_q <= '0;
      line_start_q <= '0;
      line_width_q <= '0;
      widest_q     <= '0;
      prefix_q     <= '0;
      slide_q      <= FIELD_W'(1);
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      if (take) begin
        mode_q       <= mode_d;
        pos_q        <= pos_d;
        elem_start_q <= elem_start_d;
        line_start_q <= line_start_d;
        line_width_q <= line_width_d;
        widest_q     <= widest_d;
        prefix_q     <= prefix_d;
        slide_q      <= slide_d;
        wr_ptr_q     <= PTR_W'(wr_ptr_q + PTR_W'(r0_vld) + PTR_W'(r1_vld));
      end
      if (pop) begin
        rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && r0_vld) begin
      res_q[wr_ptr_q] <= r0;
    end
    if (take && r1_vld) begin
      res_q[PTR_W'(wr_ptr_q + 1'b1)] <= r1;
    end
  end

endmodule
